>>> hdl/list_insert_delete_dump_defines.svh
// Assertion macros shared by the list insert/delete/dump block.
`ifndef LIST_INSERT_DELETE_DUMP_DEFINES_SVH
`define LIST_INSERT_DELETE_DUMP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lid_pkg.sv
// Types and constants shared by the list insert/delete/dump block.
`timescale 1ns / 1ps

package lid_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int OUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_IGNORE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_UPDATE = 2'd1,
        ST_DUMP   = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic dump;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dump_finished;
    } dp_status_t;

    typedef struct packed {
        logic              dropped;
        logic              is_empty;
        logic              last;
        logic [DATA_W-1:0] element;
    } out_item_t;

endpackage

>>> hdl/lid_ctrl.sv
// Controller state machine: sequences accept, list update and dump.
`timescale 1ns / 1ps

module lid_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  lid_pkg::cmd_t        cmd,
    output logic                 s_tready,
    input  lid_pkg::dp_status_t  status,
    output lid_pkg::ctrl_cmd_t   ctrl
);

    lid_pkg::state_t state_reg;
    lid_pkg::state_t state_next;
    logic            take;

    assign take = s_tvalid && s_tready && (cmd != lid_pkg::CMD_IGNORE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lid_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lid_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = lid_pkg::ST_UPDATE;
                end
            end
            lid_pkg::ST_UPDATE:
            begin
                state_next = lid_pkg::ST_DUMP;
            end
            lid_pkg::ST_DUMP:
            begin
                if (status.dump_finished)
                begin
                    state_next = lid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lid_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.update = 1'b0;
        ctrl.dump   = 1'b0;
        case (state_reg)
            lid_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = take;
            end
            lid_pkg::ST_UPDATE:
            begin
                ctrl.update = 1'b1;
            end
            lid_pkg::ST_DUMP:
            begin
                ctrl.dump = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/lid_ofifo.sv
// Two-entry output queue that decouples the dump from the result receiver.
`timescale 1ns / 1ps

module lid_ofifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lid_pkg::out_item_t  push_item,
    input  logic                ready,
    output logic                valid,
    output lid_pkg::out_item_t  item,
    output logic [1:0]          occ
);

    lid_pkg::out_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         occ_reg;
    logic [1:0]         occ_next;
    logic               pop;

    assign valid = (occ_reg != 2'd0);
    assign item  = slot_reg[rd_ptr_reg];
    assign occ   = occ_reg;
    assign pop   = valid && ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (push && !pop)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/lid_dp.sv
// Datapath: circular element store, list bookkeeping and the dump sequencer.
`timescale 1ns / 1ps
`include "list_insert_delete_dump_defines.svh"

module lid_dp #(
    parameter int CAPACITY = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lid_pkg::ctrl_cmd_t               ctrl,
    input  lid_pkg::cmd_t                    cmd,
    input  logic [lid_pkg::DATA_W-1:0]       operand,
    input  logic [1:0]                       fifo_occ,
    input  logic                             fifo_pop,
    output logic                             fifo_push,
    output lid_pkg::out_item_t               fifo_item,
    output lid_pkg::dp_status_t              status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_I = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] TOP_I = IDX_W'(CAPACITY - 1);

    logic [lid_pkg::DATA_W-1:0] mem [CAPACITY];

    lid_pkg::cmd_t              cmd_reg;
    logic [lid_pkg::DATA_W-1:0] opnd_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           head_next;
    logic                       drop_reg;
    logic                       drop_next;
    logic                       del_act_reg;
    logic                       del_act_next;
    logic [CNT_W-1:0]           del_pos_reg;
    logic [CNT_W-1:0]           del_pos_next;
    logic [CNT_W-1:0]           idx_reg;
    logic                       infl_reg;
    logic                       infl_last_reg;
    logic                       infl_empty_reg;
    logic                       infl_wen_reg;
    logic [IDX_W-1:0]           infl_waddr_reg;
    logic [lid_pkg::DATA_W-1:0] rdata_reg;

    logic                       upd_wen;
    logic [IDX_W-1:0]           upd_waddr;
    logic                       wen;
    logic [IDX_W-1:0]           waddr;
    logic [lid_pkg::DATA_W-1:0] wdata;
    logic [CNT_W-1:0]           total;
    logic                       done;
    logic [2:0]                 pending;
    logic                       issue;
    logic                       shift;
    logic [CNT_W-1:0]           src;
    logic [IDX_W-1:0]           rd_addr;
    logic                       is_full;
    logic                       del_ok;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] a,
                                              input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_I)
        begin
            s = s - CAP_I;
        end
        return s[IDX_W-1:0];
    endfunction

    // List update: an insert writes one word and moves the head or tail;
    // a delete only records the position and shrinks the count, the dump closes the gap.
    assign is_full = (count_reg == CAP_C);
    assign del_ok  = !opnd_reg[lid_pkg::DATA_W-1]
                     && (opnd_reg[lid_pkg::DATA_W-2:0] < (lid_pkg::DATA_W-1)'(count_reg));

    always_comb
    begin
        count_next   = count_reg;
        head_next    = head_reg;
        drop_next    = drop_reg;
        del_act_next = del_act_reg;
        del_pos_next = del_pos_reg;
        upd_wen      = 1'b0;
        upd_waddr    = head_reg;
        if (ctrl.load)
        begin
            drop_next    = 1'b0;
            del_act_next = 1'b0;
        end
        else if (ctrl.update)
        begin
            case (cmd_reg)
                lid_pkg::CMD_INS_FRONT:
                begin
                    if (is_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = (head_reg == '0) ? TOP_I : head_reg - IDX_W'(1);
                        upd_wen    = 1'b1;
                        upd_waddr  = head_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                lid_pkg::CMD_INS_BACK:
                begin
                    if (is_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        upd_wen    = 1'b1;
                        upd_waddr  = wrap(head_reg, count_reg[IDX_W-1:0]);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                lid_pkg::CMD_DELETE:
                begin
                    if (del_ok)
                    begin
                        count_next   = count_reg - CNT_W'(1);
                        del_act_next = 1'b1;
                        del_pos_next = opnd_reg[CNT_W-1:0];
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Dump: one read per cycle while the output queue has room; elements at
    // or past a deleted position are read one place further on and written
    // back one place lower.
    assign total   = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign done    = (idx_reg == total);
    assign pending = {1'b0, fifo_occ} + {2'b00, infl_reg} - {2'b00, fifo_pop};
    assign issue   = ctrl.dump && !done && (pending < 3'd2);
    assign shift   = del_act_reg && (idx_reg >= del_pos_reg);
    assign src     = idx_reg + {{(CNT_W-1){1'b0}}, shift};
    assign rd_addr = wrap(head_reg, src[IDX_W-1:0]);

    assign status.dump_finished = done && !infl_reg;

    assign fifo_push          = infl_reg;
    assign fifo_item.element  = infl_empty_reg ? '0 : rdata_reg;
    assign fifo_item.is_empty = infl_empty_reg;
    assign fifo_item.last     = infl_last_reg;
    assign fifo_item.dropped  = drop_reg;

    assign wen   = upd_wen || (infl_reg && infl_wen_reg);
    assign waddr = upd_wen ? upd_waddr : infl_waddr_reg;
    assign wdata = upd_wen ? opnd_reg : rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            head_reg    <= '0;
            drop_reg    <= 1'b0;
            del_act_reg <= 1'b0;
            del_pos_reg <= '0;
            idx_reg     <= '0;
            infl_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            head_reg    <= head_next;
            drop_reg    <= drop_next;
            del_act_reg <= del_act_next;
            del_pos_reg <= del_pos_next;
            infl_reg    <= issue;
            if (ctrl.update)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd;
            opnd_reg <= operand;
        end
        if (issue)
        begin
            infl_last_reg  <= (idx_reg + CNT_W'(1) == total);
            infl_empty_reg <= (count_reg == '0);
            infl_wen_reg   <= shift;
            infl_waddr_reg <= wrap(head_reg, idx_reg[IDX_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    `LID_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CAP_C, "list count beyond capacity")
    `LID_ASSERT_IMP(a_head_range, 1'b1, {1'b0, head_reg} < CAP_I, "head index out of range")
    `LID_ASSERT_IMP(a_no_overflow, fifo_push, (fifo_occ != 2'd2) || fifo_pop,
                    "result pushed into a full output queue")
    `LID_ASSERT_NXT(a_dump_restart, ctrl.update, idx_reg == '0 && !infl_reg,
                    "dump did not restart after a list update")

endmodule

>>> hdl/list_insert_delete_dump.sv
// Top level of the list insert/delete/dump block.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values. Commands come
// in on the s_ channel: s_tuser holds the command (insert front, insert back,
// delete at position, ignore) and s_tdata the value or the zero-based position.
// After every insert or delete the whole list goes out on the m_ channel,
// front to back, one transaction per element, with m_tlast on the final one.
// An empty list gives a single transaction flagged empty; a dropped insert
// into a full list sets the dropped flag on every transaction of its dump.
// An accepted command is registered, applied to the list in an update step,
// then dumped: the element store, which has one read port, gives one element
// per cycle while the output queue has room. An ignored command is taken
// while idle and gives no result.
// Results wait in a two-entry output queue; when the receiver stalls, the dump
// pauses with it and nothing is lost. The next command is taken once every
// read of the current dump is done, even while results still wait.
// After reset the list is empty; no clearing pass is needed.
`timescale 1ns / 1ps

module list_insert_delete_dump #(
    parameter int CAPACITY = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lid_pkg::DATA_W-1:0]        s_tdata,  // [31:0] operand
    input  logic [lid_pkg::CMD_W-1:0]         s_tuser,  // [1:0] cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lid_pkg::DATA_W-1:0]        m_tdata,  // [31:0] element
    output logic                              m_tlast,
    output logic [lid_pkg::OUSER_W-1:0]       m_tuser   // [0] is_empty, [1] dropped
);

    lid_pkg::ctrl_cmd_t  ctrl;
    lid_pkg::dp_status_t status;
    lid_pkg::cmd_t       cmd;
    lid_pkg::out_item_t  push_item;
    lid_pkg::out_item_t  out_item;
    logic                push;
    logic [1:0]          occ;
    logic                pop;

    assign cmd = lid_pkg::cmd_t'(s_tuser);
    assign pop = m_tvalid && m_tready;

    lid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .cmd      (cmd),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    lid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (cmd),
        .operand   (s_tdata),
        .fifo_occ  (occ),
        .fifo_pop  (pop),
        .fifo_push (push),
        .fifo_item (push_item),
        .status    (status)
    );

    lid_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (m_tready),
        .valid     (m_tvalid),
        .item      (out_item),
        .occ       (occ)
    );

    assign m_tdata = out_item.element;
    assign m_tlast = out_item.last;
    assign m_tuser = {out_item.dropped, out_item.is_empty};

endmodule

>>> tb/tb_list_insert_delete_dump.sv
// Self-checking testbench for the list insert/delete/dump block.
`timescale 1ns / 1ps

module tb_list_insert_delete_dump;

    localparam int LIST_DEPTH = 32;

    typedef struct packed {
        logic [lid_pkg::DATA_W-1:0] element;
        logic                       is_empty;
        logic                       last;
        logic                       dropped;
    } dump_item_t;

    typedef struct packed {
        lid_pkg::cmd_t              cmd;
        logic [lid_pkg::DATA_W-1:0] operand;
        logic                       typed;
        dump_item_t                 want;
    } script_row_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [lid_pkg::DATA_W-1:0]  s_tdata = '0;
    logic [lid_pkg::CMD_W-1:0]   s_tuser = lid_pkg::CMD_IGNORE;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [lid_pkg::DATA_W-1:0]  m_tdata;
    logic                        m_tlast;
    logic [lid_pkg::OUSER_W-1:0] m_tuser;

    logic [lid_pkg::DATA_W-1:0] held_q[$];
    dump_item_t                 pending_dump_q[$];
    int                         errors = 0;
    bit                         src_quiet = 1'b0;
    bit                         sink_quiet = 1'b0;

    // Rows with a typed result give a single, obvious transaction; the rest use the predictor.
    script_row_t script [0:19] = '{
        '{lid_pkg::CMD_DELETE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1, 1'b0}},
        '{lid_pkg::CMD_IGNORE,    32'h0000_0000, 1'b0, '0},
        '{lid_pkg::CMD_INS_FRONT, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b1, 1'b0}},
        '{lid_pkg::CMD_DELETE,    32'hFFFF_FFFF, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0001, 1'b0, '0},
        '{lid_pkg::CMD_INS_BACK,  32'h7FFF_FFFF, 1'b0, '0},
        '{lid_pkg::CMD_INS_FRONT, 32'h0000_0000, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0001, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h7FFF_FFFF, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h8000_0000, 1'b0, '0},
        '{lid_pkg::CMD_IGNORE,    32'hFFFF_FFFF, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0001, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1, 1'b0}},
        '{lid_pkg::CMD_INS_BACK,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0}},
        '{lid_pkg::CMD_DELETE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1, 1'b0}},
        '{lid_pkg::CMD_INS_BACK,  32'h5555_5555, 1'b0, '0},
        '{lid_pkg::CMD_INS_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0002, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0000, 1'b0, '0},
        '{lid_pkg::CMD_DELETE,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1, 1'b0}}
    };

    list_insert_delete_dump #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL list_insert_delete_dump");
        $finish;
    end

    function automatic void list_after_command(lid_pkg::cmd_t c,
                                               logic [lid_pkg::DATA_W-1:0] v, bit emit);
        bit         drop;
        int         n;
        dump_item_t item;
        drop = 1'b0;
        if (c == lid_pkg::CMD_IGNORE)
            return;
        if (c == lid_pkg::CMD_DELETE)
        begin
            if (!v[31] && v < held_q.size())
                held_q.delete(int'(v));
        end
        else if (held_q.size() >= LIST_DEPTH)
            drop = 1'b1;
        else if (c == lid_pkg::CMD_INS_FRONT)
            held_q.push_front(v);
        else
            held_q.push_back(v);
        if (!emit)
            return;
        n = held_q.size();
        if (n == 0)
        begin
            item = '{'0, 1'b1, 1'b1, drop};
            pending_dump_q.push_back(item);
        end
        for (int i = 0; i < n; i++)
        begin
            item = '{held_q[i], 1'b0, (i == n - 1), drop};
            pending_dump_q.push_back(item);
        end
    endfunction

    task automatic issue_command(lid_pkg::cmd_t c, logic [lid_pkg::DATA_W-1:0] v, bit typed,
                                 dump_item_t want);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= v;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        list_after_command(c, v, !typed);
        if (typed && c != lid_pkg::CMD_IGNORE)
            pending_dump_q.push_back(want);
    endtask

    task automatic report_miss(string field, logic [lid_pkg::DATA_W-1:0] want,
                               logic [lid_pkg::DATA_W-1:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    initial
    begin : sink
        int         stall;
        dump_item_t want;
        @(posedge clk);
        forever
        begin
            stall = sink_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);
            if (pending_dump_q.size() == 0)
                report_miss("unexpected transaction, element", 'x, m_tdata);
            else
            begin
                want = pending_dump_q.pop_front();
                if (m_tdata !== want.element)
                    report_miss("element", want.element, m_tdata);
                if (m_tuser[0] !== want.is_empty)
                    report_miss("is_empty", want.is_empty, m_tuser[0]);
                if (m_tlast !== want.last)
                    report_miss("last", want.last, m_tlast);
                if (m_tuser[1] !== want.dropped)
                    report_miss("dropped", want.dropped, m_tuser[1]);
            end
            if ($urandom_range(0, 39) == 0)
                sink_quiet = !sink_quiet;
        end
    end

    initial
    begin : source
        lid_pkg::cmd_t              c;
        logic [lid_pkg::DATA_W-1:0] v;
        int                         ins_pct;
        int                         n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (script[i])
            issue_command(script[i].cmd, script[i].operand, script[i].typed, script[i].want);
        // Phases cycle through filling to capacity, draining and a mix of both.
        for (int p = 0; p < 7; p++)
        begin
            src_quiet = ($urandom_range(0, 3) == 0);
            ins_pct = (p % 3 == 0) ? 95 : (p % 3 == 1) ? 15 : 50;
            for (int k = 0; k < 36; k++)
            begin
                n = held_q.size();
                if ($urandom_range(0, 99) < 4)
                begin
                    c = lid_pkg::CMD_IGNORE;
                    v = $urandom;
                end
                else if ($urandom_range(0, 99) < ins_pct)
                begin
                    c = $urandom_range(0, 1) ? lid_pkg::CMD_INS_BACK : lid_pkg::CMD_INS_FRONT;
                    case ($urandom_range(0, 9))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = '0;
                        3: v = '1;
                        default: v = $urandom;
                    endcase
                end
                else
                begin
                    c = lid_pkg::CMD_DELETE;
                    if (n > 0 && $urandom_range(0, 99) < 75)
                        v = $urandom_range(0, n - 1);
                    else
                        case ($urandom_range(0, 3))
                            0: v = n;
                            1: v = n + $urandom_range(1, 64);
                            2: v = {1'b1, 31'($urandom)};
                            default: v = $urandom;
                        endcase
                end
                issue_command(c, v, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_dump_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS list_insert_delete_dump");
        else
            $display("FAIL list_insert_delete_dump");
        $finish;
    end

endmodule
